### src/htps_pkg.sv
// Shared types and constants for the humidity and temperature poll sequencer.
// No dependencies; imported by the core, the top level and the checker.
`timescale 1ns / 1ps

package htps_pkg;

	// Packed widths of the stream payloads
	localparam int unsigned InDataW  = 56;
	localparam int unsigned OutDataW = 40;
	localparam int unsigned OutUserW = 4;

	// Sensor trigger command bytes
	localparam logic [7:0] CMD_NONE      = 8'h00;
	localparam logic [7:0] CMD_TRIG_TEMP = 8'hE3;
	localparam logic [7:0] CMD_TRIG_HUMI = 8'hE5;

	// Reset values of the delay registers, in milliseconds
	localparam logic [7:0] IDLE_DELAY_RST    = 8'd90;
	localparam logic [7:0] MEASURE_DELAY_RST = 8'd16;

	// Conversion constants: value = (scale * raw) >> 16 - offset
	localparam logic [14:0] TEMP_SCALE  = 15'd17572;
	localparam logic [15:0] TEMP_OFFSET = 16'd4685;
	localparam logic [13:0] HUMI_SCALE  = 14'd12500;
	localparam logic [15:0] HUMI_OFFSET = 16'd600;

	// Configuration register indexes
	localparam logic REG_IDLE_DELAY    = 1'b0;
	localparam logic REG_MEASURE_DELAY = 1'b1;

	// Result action codes
	typedef enum logic [2:0] {
		ACT_TOO_EARLY = 3'd0,
		ACT_TEMP_TRIG = 3'd1,
		ACT_HUMI_TRIG = 3'd2,
		ACT_FAIL      = 3'd3,
		ACT_PAIR      = 3'd4
	} action_t;

	// Polling phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_TEMP = 3'b010,
		PH_HUMI = 3'b100
	} phase_t;

	// One poll call
	typedef struct packed {
		logic [15:0] read_word;
		logic        read_ok;
		logic        command_ok;
		logic [31:0] now_ms;
	} poll_item_t;

	// One result
	typedef struct packed {
		logic               pair_valid;
		logic signed [14:0] humidity_centi;
		logic signed [14:0] temperature_centi;
		logic [7:0]         command_code;
		action_t            action;
	} poll_result_t;

endpackage

### src/humidity_temperature_poll_sequencer.sv
// Top level of the humidity and temperature poll sequencer: stream ports,
// input and output registers. Depends on htps_pkg and htps_core.
`timescale 1ns / 1ps

// Each input transfer is one poll call and yields exactly one result transfer.
// A call passes an input register, is evaluated against the sequencer state
// combinationally and lands in an output register; one call can be taken
// every cycle while m_tready does not stall the output register. The phase,
// time and delay registers in the core are updated in the cycle that evaluates
// a call, which is what lets the following call use them straight away. The
// user must write the delay registers through the cfg port only while no call
// is in flight; the block itself does not enforce it. A new value is loaded
// when the next due call sets the delay.
module humidity_temperature_poll_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port
	input  logic                          cfg_wr_en,
	input  logic                          cfg_index,
	input  logic [7:0]                    cfg_wdata,
	// Poll call stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// now_ms[31:0], command_ok[32], read_ok[33], read_word[49:34], zero[55:50]
	input  logic [htps_pkg::InDataW-1:0]  s_tdata,
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// command_code[7:0], temperature_centi[22:8], humidity_centi[37:23],
	// zero[39:38]
	output logic [htps_pkg::OutDataW-1:0] m_tdata,
	// action[2:0], pair_valid[3]
	output logic [htps_pkg::OutUserW-1:0] m_tuser
);
	import htps_pkg::*;

	logic         valid_s1;
	poll_item_t   item_s1;
	logic         advance;
	poll_result_t result;
	poll_result_t result_q;

	// The input stage moves on whenever the output register is free or drained
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_tdata[$bits(poll_item_t)-1:0];
		end
	end

	htps_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item      (item_s1),
		.result    (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tdata = {2'b00, result_q.humidity_centi, result_q.temperature_centi,
		result_q.command_code};
	assign m_tuser = {result_q.pair_valid, result_q.action};

endmodule

### src/htps_core.sv
// Sequencer state, delay registers and the single-pass step logic.
// Depends on htps_pkg.
`timescale 1ns / 1ps

module htps_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_wdata,
	input  logic                  advance,
	input  htps_pkg::poll_item_t  item,
	output htps_pkg::poll_result_t result
);
	import htps_pkg::*;

	logic [7:0]         idle_delay_q;
	logic [7:0]         measure_delay_q;
	phase_t             phase_q;
	phase_t             phase_d;
	logic [31:0]        last_time_q;
	logic [7:0]         delay_q;
	logic [7:0]         delay_d;
	logic signed [14:0] temp_q;
	logic signed [14:0] temp_d;
	logic signed [14:0] humi_q;
	logic signed [14:0] humi_d;
	logic [31:0]        elapsed;
	logic               due;
	logic [30:0]        temp_prod;
	logic [29:0]        humi_prod;
	logic [15:0]        temp_conv;
	logic [15:0]        humi_conv;
	action_t            action;
	logic [7:0]         code;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_delay_q    <= IDLE_DELAY_RST;
			measure_delay_q <= MEASURE_DELAY_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_IDLE_DELAY) begin
				idle_delay_q <= cfg_wdata;
			end else begin
				measure_delay_q <= cfg_wdata;
			end
		end
	end

	// Raw samples scaled by constant multipliers and offset
	assign temp_prod = 31'(TEMP_SCALE) * 31'(item.read_word);
	assign humi_prod = 30'(HUMI_SCALE) * 30'(item.read_word);
	assign temp_conv = {1'b0, temp_prod[30:16]} - TEMP_OFFSET;
	assign humi_conv = {2'b00, humi_prod[29:16]} - HUMI_OFFSET;

	// The call acts only once the wrapped elapsed time exceeds the delay
	assign elapsed = item.now_ms - last_time_q;
	assign due     = elapsed > {24'd0, delay_q};

	// Phase step
	always_comb begin
		phase_d = phase_q;
		delay_d = delay_q;
		temp_d  = temp_q;
		humi_d  = humi_q;
		action  = ACT_TOO_EARLY;
		code    = CMD_NONE;
		if (due) begin
			case (phase_q)
				PH_IDLE: begin
					code = CMD_TRIG_TEMP;
					if (item.command_ok) begin
						phase_d = PH_TEMP;
						delay_d = measure_delay_q;
						action  = ACT_TEMP_TRIG;
					end else begin
						delay_d = idle_delay_q;
						action  = ACT_FAIL;
					end
				end
				PH_TEMP: begin
					if (item.read_ok) begin
						code = CMD_TRIG_HUMI;
					end
					if (item.read_ok && item.command_ok) begin
						phase_d = PH_HUMI;
						temp_d  = temp_conv[14:0];
						delay_d = measure_delay_q;
						action  = ACT_HUMI_TRIG;
					end else begin
						phase_d = PH_IDLE;
						delay_d = idle_delay_q;
						action  = ACT_FAIL;
					end
				end
				PH_HUMI: begin
					if (item.read_ok) begin
						humi_d = humi_conv[14:0];
						action = ACT_PAIR;
					end else begin
						action = ACT_FAIL;
					end
					phase_d = PH_IDLE;
					delay_d = idle_delay_q;
				end
				default: begin
					phase_d = PH_IDLE;
					delay_d = idle_delay_q;
					action  = ACT_FAIL;
				end
			endcase
		end
	end

	// Sequencer state, updated once per item leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			last_time_q <= 32'd0;
			delay_q     <= IDLE_DELAY_RST;
			temp_q      <= 15'sd0;
			humi_q      <= 15'sd0;
		end else if (advance) begin
			phase_q <= phase_d;
			delay_q <= delay_d;
			temp_q  <= temp_d;
			humi_q  <= humi_d;
			if (due) begin
				last_time_q <= item.now_ms;
			end
		end
	end

	// Result shows the held values after this call
	always_comb begin
		result.action            = action;
		result.command_code      = code;
		result.temperature_centi = temp_d;
		result.humidity_centi    = humi_d;
		result.pair_valid        = (action == ACT_PAIR);
	end

endmodule

### src/htps_checker.sv
// Port-level checker for the poll sequencer, bound to the top level.
// Depends on htps_pkg and humidity_temperature_poll_sequencer.
`timescale 1ns / 1ps

module htps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [htps_pkg::OutDataW-1:0] m_tdata,
	input logic [htps_pkg::OutUserW-1:0] m_tuser
);
	import htps_pkg::*;

	// A pair is flagged exactly when the action says it was emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[3] == (m_tuser[2:0] == ACT_PAIR)))
		else $error("pair flag disagrees with action");

	// A too-early call attempts no command
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] == ACT_TOO_EARLY) |-> (m_tdata[7:0] == CMD_NONE))
		else $error("command reported on a too-early call");

	// Successful triggers report the matching command byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] == ACT_TEMP_TRIG) |-> (m_tdata[7:0] == CMD_TRIG_TEMP))
		else $error("temperature trigger without its command byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2:0] == ACT_HUMI_TRIG) |-> (m_tdata[7:0] == CMD_TRIG_HUMI))
		else $error("humidity trigger without its command byte");

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind humidity_temperature_poll_sequencer htps_checker u_htps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
